// ===== hw/rtl/bsl_pkg.sv =====
`default_nettype none
package bsl_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] REQ_FRONT  = 2'd0;
  localparam logic [KIND_W-1:0] REQ_BACK   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_DELETE = 2'd2;

  typedef struct packed {
    logic present;
    logic last;
    logic dropped;
  } out_meta_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bsl_mem.sv =====
`default_nettype none
module bsl_mem #(
  parameter int CAPACITY = 32,
  parameter int IDX_W    = 5
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [IDX_W-1:0]            wr_addr,
  input  wire logic [bsl_pkg::VALUE_W-1:0] wr_data,
  input  wire logic                        rda_en,
  input  wire logic [IDX_W-1:0]            rda_addr,
  output logic      [bsl_pkg::VALUE_W-1:0] rda_data,
  input  wire logic                        rdb_en,
  input  wire logic [IDX_W-1:0]            rdb_addr,
  output logic      [bsl_pkg::VALUE_W-1:0] rdb_data
);

  logic [bsl_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [bsl_pkg::VALUE_W-1:0] rda_data_r;
  logic [bsl_pkg::VALUE_W-1:0] rdb_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rda_en) begin
      rda_data_r <= mem[rda_addr];
    end
    if (rdb_en) begin
      rdb_data_r <= mem[rdb_addr];
    end
  end

  assign rda_data = rda_data_r;
  assign rdb_data = rdb_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bsl_ctrl.sv =====
`default_nettype none
module bsl_ctrl #(
  parameter int CAPACITY = 32,
  parameter int IDX_W    = 5,
  parameter int CNT_W    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bsl_pkg::KIND_W-1:0]  req_type,
  input  wire logic [bsl_pkg::VALUE_W-1:0] item_value,
  input  wire logic [bsl_pkg::POS_W-1:0]   position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bsl_pkg::out_meta_t               out_meta,
  output logic                             wr_en,
  output logic      [IDX_W-1:0]            wr_addr,
  output logic      [bsl_pkg::VALUE_W-1:0] wr_data,
  output logic                             rda_en,
  output logic      [IDX_W-1:0]            rda_addr,
  output logic                             rdb_en,
  output logic      [IDX_W-1:0]            rdb_addr,
  input  wire logic [bsl_pkg::VALUE_W-1:0] rdb_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_DUMP  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  function automatic logic [IDX_W-1:0] ph_inc(input logic [IDX_W-1:0] p);
    ph_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ph_dec(input logic [IDX_W-1:0] p);
    ph_dec = (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ph_add(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    ph_add = sum[IDX_W-1:0];
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   src_off_r, src_off_nxt;
  logic [IDX_W-1:0]   src_ph_r, src_ph_nxt;
  logic [IDX_W-1:0]   prev_ph_r, prev_ph_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]   wr_ph_r, wr_ph_nxt;
  logic [CNT_W-1:0]   dump_off_r, dump_off_nxt;
  logic [IDX_W-1:0]   dump_ph_r, dump_ph_nxt;
  logic               dropped_r, dropped_nxt;
  logic               out_valid_r, out_valid_nxt;
  bsl_pkg::out_meta_t meta_r, meta_nxt;

  logic               full;
  logic               issue;
  logic [IDX_W-1:0]   del_ph;

  assign full   = (cnt_r == CAP_CNT);
  assign issue  = !out_valid_r || out_ready;
  assign del_ph = ph_add(head_r, position[IDX_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    src_off_nxt   = src_off_r;
    src_ph_nxt    = src_ph_r;
    prev_ph_nxt   = prev_ph_r;
    wr_pend_nxt   = wr_pend_r;
    wr_ph_nxt     = wr_ph_r;
    dump_off_nxt  = dump_off_r;
    dump_ph_nxt   = dump_ph_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_ready;
    meta_nxt      = meta_r;
    wr_en         = 1'b0;
    wr_addr       = wr_ph_r;
    wr_data       = rdb_data;
    rda_en        = 1'b0;
    rda_addr      = dump_ph_r;
    rdb_en        = 1'b0;
    rdb_addr      = src_ph_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dropped_nxt  = 1'b0;
          dump_off_nxt = '0;
          state_nxt    = S_DUMP;
          case (req_type)
            bsl_pkg::REQ_FRONT: begin
              if (full) begin
                dropped_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = ph_dec(head_r);
                wr_data  = item_value;
                head_nxt = ph_dec(head_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            bsl_pkg::REQ_BACK: begin
              if (full) begin
                dropped_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ph_add(head_r, cnt_r[IDX_W-1:0]);
                wr_data = item_value;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            bsl_pkg::REQ_DELETE: begin
              if (position < bsl_pkg::POS_W'(cnt_r)) begin
                if (position == bsl_pkg::POS_W'(cnt_r - 1'b1)) begin
                  cnt_nxt = cnt_r - 1'b1;
                end else begin
                  state_nxt   = S_SHIFT;
                  prev_ph_nxt = del_ph;
                  src_ph_nxt  = ph_inc(del_ph);
                  src_off_nxt = CNT_W'(position[IDX_W-1:0]) + 1'b1;
                  wr_pend_nxt = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
          dump_ph_nxt = head_nxt;
        end
      end
      S_SHIFT: begin
        if (wr_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_ph_r;
          wr_data = rdb_data;
        end
        if (src_off_r < cnt_r) begin
          rdb_en      = 1'b1;
          rdb_addr    = src_ph_r;
          wr_ph_nxt   = prev_ph_r;
          prev_ph_nxt = src_ph_r;
          src_ph_nxt  = ph_inc(src_ph_r);
          src_off_nxt = src_off_r + 1'b1;
          wr_pend_nxt = 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (issue) begin
          out_valid_nxt    = 1'b1;
          meta_nxt.dropped = dropped_r;
          if (cnt_r == '0) begin
            meta_nxt.present = 1'b0;
            meta_nxt.last    = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            rda_en           = 1'b1;
            rda_addr         = dump_ph_r;
            meta_nxt.present = 1'b1;
            meta_nxt.last    = (dump_off_r == cnt_r - 1'b1);
            dump_off_nxt     = dump_off_r + 1'b1;
            dump_ph_nxt      = ph_inc(dump_ph_r);
            if (dump_off_r == cnt_r - 1'b1) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_off_r  <= src_off_nxt;
    src_ph_r   <= src_ph_nxt;
    prev_ph_r  <= prev_ph_nxt;
    wr_ph_r    <= wr_ph_nxt;
    dump_off_r <= dump_off_nxt;
    dump_ph_r  <= dump_ph_nxt;
    meta_r     <= meta_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_meta  = meta_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bounded_sequence_list_top.sv =====
`default_nettype none
// Flow: a taken request moves the controller to its dump state, which reads the list memory
// into a registered report word; a delete that closes a gap first passes through the shift
// state, which moves each later entry down by one place. A new request is taken only once
// the report of the last one is complete, so the move time of a delete and any output stalls
// delay it; the report reads one word per cycle from the list memory while out_tready is high.
// Reset: synchronous, active low; the list becomes empty, and the storage is not cleared.
module bounded_sequence_list_top #(
  parameter int CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // item_value [31:0], position [39:32]
  input  wire logic [1:0]  in_tuser,   // req_type [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // entry_value [31:0]
  output logic      [1:0]  out_tuser,  // entry_present [0], insert_dropped [1]
  output logic             out_tlast
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [bsl_pkg::VALUE_W-1:0] wr_data;
  logic                        rda_en;
  logic [IDX_W-1:0]            rda_addr;
  logic [bsl_pkg::VALUE_W-1:0] rda_data;
  logic                        rdb_en;
  logic [IDX_W-1:0]            rdb_addr;
  logic [bsl_pkg::VALUE_W-1:0] rdb_data;
  bsl_pkg::out_meta_t          meta;

  bsl_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .item_value (in_tdata[31:0]),
    .position   (in_tdata[39:32]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_meta   (meta),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rda_en     (rda_en),
    .rda_addr   (rda_addr),
    .rdb_en     (rdb_en),
    .rdb_addr   (rdb_addr),
    .rdb_data   (rdb_data)
  );

  bsl_mem #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rda_en   (rda_en),
    .rda_addr (rda_addr),
    .rda_data (rda_data),
    .rdb_en   (rdb_en),
    .rdb_addr (rdb_addr),
    .rdb_data (rdb_data)
  );

  assign out_tdata = meta.present ? rda_data : '0;
  assign out_tuser = {meta.dropped, meta.present};
  assign out_tlast = meta.last;

endmodule
`default_nettype wire

// ===== test/bsl_report_checker.sv =====
module bsl_report_checker
  import bsl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  input  wire logic                     in_tready,
  input  wire logic [POS_W+VALUE_W-1:0] in_tdata,
  input  wire logic [KIND_W-1:0]        in_tuser,
  input  wire logic                     out_tvalid,
  input  wire logic                     out_tready,
  input  wire logic [VALUE_W-1:0]       out_tdata,
  input  wire logic [1:0]               out_tuser,
  input  wire logic                     out_tlast,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VALUE_W-1:0] entry_value;
    logic               present;
    logic               last_flag;
    logic               dropped;
  } list_word_t;

  list_word_t         report_q[$];
  logic [VALUE_W-1:0] shadow_list[CAPACITY];
  int                 shadow_count;
  int                 errors;

  initial begin
    shadow_count = 0;
    errors       = 0;
    fail_count   = 0;
    pending      = 0;
  end

  function automatic void apply_request(input logic [KIND_W-1:0] kind,
                                        input logic [VALUE_W-1:0] value,
                                        input logic [POS_W-1:0] pos);
    logic       dropped;
    int         i;
    list_word_t w;
    dropped = 1'b0;
    case (kind)
      REQ_FRONT, REQ_BACK: begin
        if (shadow_count >= CAPACITY) begin
          dropped = 1'b1;
        end else if (kind == REQ_FRONT) begin
          for (i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = value;
          shadow_count++;
        end else begin
          shadow_list[shadow_count] = value;
          shadow_count++;
        end
      end
      REQ_DELETE: begin
        if (int'(pos) < shadow_count) begin
          for (i = int'(pos); i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      default: ;
    endcase

    if (shadow_count == 0) begin
      w = '{entry_value: '0, present: 1'b0, last_flag: 1'b1, dropped: dropped};
      report_q.push_back(w);
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        w = '{entry_value: shadow_list[i], present: 1'b1,
              last_flag: (i + 1 == shadow_count), dropped: dropped};
        report_q.push_back(w);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    list_word_t want;
    if (!rst_n) begin
      shadow_count = 0;
      report_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        apply_request(in_tuser, in_tdata[VALUE_W-1:0], in_tdata[POS_W+VALUE_W-1:VALUE_W]);
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h user %b last %b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = report_q.pop_front();
          check_field("entry_value", want.entry_value, out_tdata);
          check_field("entry_present", VALUE_W'(want.present), VALUE_W'(out_tuser[0]));
          check_field("insert_dropped", VALUE_W'(want.dropped), VALUE_W'(out_tuser[1]));
          check_field("last_entry", VALUE_W'(want.last_flag), VALUE_W'(out_tlast));
        end
      end
    end
    fail_count <= errors;
    pending    <= report_q.size();
  end

endmodule

// ===== test/bounded_sequence_list_top_tb.sv =====
module bounded_sequence_list_top_tb;
  import bsl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                CAPACITY     = 32;
  localparam int                QUIET_LIMIT  = 2000;
  localparam int                RANDOM_ITEMS = 260;
  localparam logic [KIND_W-1:0] REQ_NONE     = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [POS_W+VALUE_W-1:0] in_tdata;
  logic [KIND_W-1:0]        in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [VALUE_W-1:0]       out_tdata;
  logic [1:0]               out_tuser;
  logic                     out_tlast;

  int fail_count;
  int pending;
  int list_len;
  int sent;
  int quiet_cycles;
  int stall_left;
  int stall_draw;
  bit no_gaps;

  bounded_sequence_list_top #(.CAPACITY(CAPACITY)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  bsl_report_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver draws a fresh stall after every word it takes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      stall_draw = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall_draw != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_draw;
      end
    end else if (!out_tready) begin
      if (stall_left <= 1) out_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pos, value};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    case (kind)
      REQ_FRONT, REQ_BACK: if (list_len < CAPACITY) list_len++;
      REQ_DELETE:          if (int'(pos) < list_len) list_len--;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed requests; the remainder are deletes at a random position from 0 to 255 and type 3 words.
  task automatic random_request(input int insert_pct, input int delete_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct)
      send_request($urandom_range(0, 1) ? REQ_BACK : REQ_FRONT, $urandom(),
                   POS_W'($urandom()));
    else if (r < insert_pct + delete_pct && list_len > 0)
      send_request(REQ_DELETE, $urandom(), POS_W'($urandom_range(0, list_len - 1)));
    else if (r[0])
      send_request(REQ_DELETE, $urandom(), POS_W'($urandom_range(0, 255)));
    else
      send_request(REQ_NONE, $urandom(), POS_W'($urandom()));
  endtask

  initial begin
    int phase;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_FRONT;
    out_tready = 1'b0;
    no_gaps    = 1'b0;
    list_len   = 0;
    sent       = 0;
    phase      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_request(REQ_DELETE, 32'h0, 8'd0);
    send_request(REQ_NONE, 32'hffff_ffff, 8'hff);
    send_request(REQ_FRONT, 32'h7fff_ffff, 8'h00);
    send_request(REQ_BACK, 32'h8000_0000, 8'hff);
    send_request(REQ_FRONT, 32'h0000_0000, 8'h55);
    send_request(REQ_BACK, 32'hffff_ffff, 8'haa);
    send_request(REQ_FRONT, 32'h0000_0001, 8'h00);
    send_request(REQ_NONE, 32'h5555_5555, 8'd1);
    send_request(REQ_DELETE, 32'hdead_beef, 8'd255);
    send_request(REQ_DELETE, 32'h0, 8'd5);
    send_request(REQ_DELETE, 32'h0, 8'd4);
    send_request(REQ_DELETE, 32'h0, 8'd0);
    send_request(REQ_DELETE, 32'h0, 8'd1);
    send_request(REQ_DELETE, 32'h0, 8'd0);
    send_request(REQ_DELETE, 32'h0, 8'd0);
    send_request(REQ_DELETE, 32'h0, 8'd0);
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      case (phase % 3)
        0: begin
          while (list_len < CAPACITY) random_request(88, 8);
          repeat ($urandom_range(2, 5)) random_request(100, 0);
        end
        1: begin
          while (list_len > 0) random_request(10, 82);
          repeat ($urandom_range(1, 3)) random_request(0, 100);
        end
        default: repeat ($urandom_range(20, 35)) random_request(45, 45);
      endcase
      if ($urandom_range(0, 1)) wait_drained();
      phase++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bsl_pkg.sv
hw/rtl/bsl_mem.sv
hw/rtl/bsl_ctrl.sv
hw/rtl/bounded_sequence_list_top.sv
test/bsl_report_checker.sv
test/bounded_sequence_list_top_tb.sv
